// ----- src/tcst_pkg.sv -----
`timescale 1ns / 1ps

package tcst_pkg;

    localparam int NUM_IDS_DEF     = 21;
    localparam int NUM_SLOTS_DEF   = 20;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int REPORT_CONTACTS = 6;
    localparam int FULL_SCALE      = 32767;

    localparam int POS_W    = 16;
    localparam int SCREEN_W = 13;
    localparam int PROD_W   = POS_W + SCREEN_W;

    localparam logic [3:0] ST_TOUCH = 4'd7;
    localparam logic [3:0] ST_LIFT  = 4'd4;

    typedef enum logic [1:0] {
        CFG_ENABLE = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } tcst_cfg_idx_t;

    typedef enum logic [1:0] {
        PH_DOWN = 2'd0,
        PH_UP   = 2'd1,
        PH_MOVE = 2'd2
    } tcst_phase_t;

    typedef struct packed {
        logic [3:0]       typ;
        logic [4:0]       slot;
        tcst_phase_t      phase;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [15:0]      w;
        logic [15:0]      h;
    } tcst_item_t;

    // floor(p / 32767) as p = a*2^15 + b = a*32767 + (a + b); a + b < 2*32767
    function automatic logic [POS_W-1:0] tcst_reduce(input logic [PROD_W-1:0] p);
        logic [PROD_W-16:0] a;
        logic [14:0]        b;
        logic [16:0]        s;
        logic [PROD_W-14:0] q;
        a = p[PROD_W-1:15];
        b = p[14:0];
        s = 17'(a) + 17'(b);
        q = (PROD_W-13)'(a) + ((s >= 17'(FULL_SCALE)) ? (PROD_W-13)'(1) : '0);
        if (q > (PROD_W-13)'(16'hFFFF))
            return 16'hFFFF;
        else
            return POS_W'(q);
    endfunction

endpackage

// ----- src/tcst_front.sv -----
`timescale 1ns / 1ps

module tcst_front #(
    parameter int NUM_IDS   = tcst_pkg::NUM_IDS_DEF,
    parameter int NUM_SLOTS = tcst_pkg::NUM_SLOTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fwd_en,
    input  logic                 in_valid,
    input  logic                 first_contact,
    input  logic [3:0]           contact_state,
    input  logic [3:0]           contact_type,
    input  logic [7:0]           contact_id,
    input  logic [15:0]          x_raw,
    input  logic [15:0]          y_raw,
    input  logic [15:0]          contact_width,
    input  logic [15:0]          contact_height,
    output logic                 q_push,
    output tcst_pkg::tcst_item_t q_item
);

    localparam int ID_W   = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [NUM_IDS-1:0]   valid_reg, valid_next;
    logic [SLOT_W-1:0]    idx_reg   [NUM_IDS];
    logic [SLOT_W-1:0]    idx_next  [NUM_IDS];
    tcst_pkg::tcst_phase_t phase_reg  [NUM_IDS];
    tcst_pkg::tcst_phase_t phase_next [NUM_IDS];
    logic [NUM_SLOTS-1:0] busy_reg, busy_next;
    logic                 skip_reg, skip_next;
    logic [2:0]           cnt_reg, cnt_next;

    logic                  found;
    logic [SLOT_W-1:0]     free_idx;
    logic                  skip_eff;
    logic [2:0]            cnt_eff;
    logic                  zero_pos;
    logic                  id_ok;
    logic [ID_W-1:0]       id_sel;
    logic                  cur_valid;
    logic [SLOT_W-1:0]     cur_idx;
    tcst_pkg::tcst_phase_t cur_phase;
    logic                  emit;
    logic [SLOT_W-1:0]     sel_idx;
    tcst_pkg::tcst_phase_t sel_phase;
    logic [SLOT_W:0]       slot_plus;

    // lowest free slot
    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--)
        begin
            if (!busy_reg[k])
            begin
                found    = 1'b1;
                free_idx = SLOT_W'(k);
            end
        end
    end

    assign skip_eff  = first_contact ? 1'b0 : skip_reg;
    assign cnt_eff   = first_contact ? 3'd0 : cnt_reg;
    assign zero_pos  = (x_raw == 16'd0) && (y_raw == 16'd0);
    assign id_ok     = contact_id < 8'(NUM_IDS);
    assign id_sel    = contact_id[ID_W-1:0];
    assign cur_valid = id_ok ? valid_reg[id_sel] : 1'b0;
    assign cur_idx   = id_ok ? idx_reg[id_sel] : '0;
    assign cur_phase = id_ok ? phase_reg[id_sel] : tcst_pkg::PH_DOWN;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        skip_next  = skip_reg;
        cnt_next   = cnt_reg;
        emit       = 1'b0;
        sel_idx    = cur_idx;
        sel_phase  = cur_phase;
        if (in_valid && fwd_en)
        begin
            skip_next = skip_eff;
            cnt_next  = cnt_eff;
            if (!skip_eff)
            begin
                if (cnt_eff >= 3'(tcst_pkg::REPORT_CONTACTS))
                begin
                    skip_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_eff + 3'd1;
                    if (zero_pos || !id_ok)
                    begin
                        skip_next = 1'b1;
                    end
                    else
                    begin
                        unique case (contact_state)
                            tcst_pkg::ST_TOUCH:
                            begin
                                if (!cur_valid)
                                begin
                                    if (found)
                                    begin
                                        busy_next[free_idx] = 1'b1;
                                        valid_next[id_sel]  = 1'b1;
                                        idx_next[id_sel]    = free_idx;
                                        phase_next[id_sel]  = tcst_pkg::PH_DOWN;
                                        emit                = 1'b1;
                                        sel_idx             = free_idx;
                                        sel_phase           = tcst_pkg::PH_DOWN;
                                    end
                                end
                                else
                                begin
                                    emit = 1'b1;
                                    if (cur_phase == tcst_pkg::PH_DOWN)
                                    begin
                                        sel_phase          = tcst_pkg::PH_MOVE;
                                        phase_next[id_sel] = tcst_pkg::PH_MOVE;
                                    end
                                end
                            end
                            tcst_pkg::ST_LIFT:
                            begin
                                if (cur_valid)
                                begin
                                    // report as up, then release the slot
                                    emit               = 1'b1;
                                    sel_phase          = tcst_pkg::PH_UP;
                                    busy_next[cur_idx] = 1'b0;
                                    valid_next[id_sel] = 1'b0;
                                    idx_next[id_sel]   = '0;
                                    phase_next[id_sel] = tcst_pkg::PH_DOWN;
                                end
                            end
                            default:
                            begin
                                emit = cur_valid;
                            end
                        endcase
                    end
                end
            end
        end
    end

    assign slot_plus    = {1'b0, sel_idx} + (SLOT_W+1)'(1);
    assign q_push       = emit;
    assign q_item.typ   = contact_type;
    assign q_item.slot  = 5'(slot_plus);
    assign q_item.phase = sel_phase;
    assign q_item.x     = x_raw;
    assign q_item.y     = y_raw;
    assign q_item.w     = contact_width;
    assign q_item.h     = contact_height;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            busy_reg  <= '0;
            skip_reg  <= 1'b0;
            cnt_reg   <= 3'd0;
            for (int i = 0; i < NUM_IDS; i++)
            begin
                idx_reg[i]   <= '0;
                phase_reg[i] <= tcst_pkg::PH_DOWN;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            busy_reg  <= busy_next;
            skip_reg  <= skip_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
        end
    end

    a_slot_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(busy_reg) == $countones(valid_reg))
        else $error("busy slots and tracked ids disagree");

    a_disabled_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !fwd_en) |=> ($stable(busy_reg) && $stable(valid_reg)
                                   && $stable(skip_reg) && $stable(cnt_reg)))
        else $error("state changed while forwarding disabled");

    a_report_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(tcst_pkg::REPORT_CONTACTS))
        else $error("report contact count overran");

endmodule

// ----- src/tcst_queue.sv -----
`timescale 1ns / 1ps

module tcst_queue #(
    parameter int DEPTH = tcst_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tcst_pkg::tcst_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output tcst_pkg::tcst_item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcst_pkg::tcst_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

// ----- src/tcst_back.sv -----
`timescale 1ns / 1ps

module tcst_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tcst_pkg::SCREEN_W-1:0] screen_width,
    input  logic [tcst_pkg::SCREEN_W-1:0] screen_height,
    input  logic                          q_empty,
    input  tcst_pkg::tcst_item_t          q_item,
    output logic                          q_pop,
    output logic                          res_valid,
    input  logic                          res_take,
    output tcst_pkg::tcst_item_t          res_item
);

    // stage 1: products
    logic                          s1_valid_reg, s1_valid_next;
    tcst_pkg::tcst_item_t          s1_item_reg;
    logic [tcst_pkg::PROD_W-1:0]   prod_x_reg;
    logic [tcst_pkg::PROD_W-1:0]   prod_y_reg;
    // stage 2: result register
    logic                          out_valid_reg, out_valid_next;
    tcst_pkg::tcst_item_t          out_item_reg, out_item_next;

    logic out_ready;
    logic s1_adv;

    assign out_ready = !out_valid_reg || res_take;
    assign s1_adv    = !s1_valid_reg || out_ready;
    assign q_pop     = s1_adv && !q_empty;

    always_comb
    begin
        s1_valid_next  = s1_adv ? !q_empty : s1_valid_reg;
        out_valid_next = out_ready ? s1_valid_reg : out_valid_reg;
        out_item_next   = s1_item_reg;
        out_item_next.x = tcst_pkg::tcst_reduce(prod_x_reg);
        out_item_next.y = tcst_pkg::tcst_reduce(prod_y_reg);
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_item_reg <= q_item;
            prod_x_reg  <= tcst_pkg::PROD_W'(q_item.x) * tcst_pkg::PROD_W'(screen_width);
            prod_y_reg  <= tcst_pkg::PROD_W'(q_item.y) * tcst_pkg::PROD_W'(screen_height);
        end
        if (out_ready && s1_valid_reg)
            out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_item_reg;

    a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without a product stage entry");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_ready) |=> s1_valid_reg)
        else $error("product stage lost an entry under stall");

endmodule

// ----- src/touch_contact_slot_tracker.sv -----
`timescale 1ns / 1ps

// Channel   Ports                                   Request moves when
// contact   push/full + 8 contact fields            push && !full
// result    empty/pop + 7 result fields             pop && !empty
// config    cfg_write, cfg_index, cfg_data          cfg_write
//
// One contact per cycle in while full is low; slot lookup and assignment finish
// in the accepting cycle; results then pass the queue, multiply and reduce registers.
// full rises only when the two-entry front queue backs up behind a stalled result.
// Reset clears tracking, slot map, skip state and registers (disabled, 1920 x 1080).

module touch_contact_slot_tracker #(
    parameter int NUM_IDS     = tcst_pkg::NUM_IDS_DEF,
    parameter int NUM_SLOTS   = tcst_pkg::NUM_SLOTS_DEF,
    parameter int QUEUE_DEPTH = tcst_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        first_contact,
    input  logic [3:0]  contact_state,
    input  logic [3:0]  contact_type,
    input  logic [7:0]  contact_id,
    input  logic [15:0] x_raw,
    input  logic [15:0] y_raw,
    input  logic [15:0] contact_width,
    input  logic [15:0] contact_height,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  out_type,
    output logic [4:0]  slot_number,
    output logic [1:0]  phase,
    output logic [15:0] x_scaled,
    output logic [15:0] y_scaled,
    output logic [15:0] out_width,
    output logic [15:0] out_height,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    logic                          fwd_en_reg;
    logic [tcst_pkg::SCREEN_W-1:0] scr_w_reg;
    logic [tcst_pkg::SCREEN_W-1:0] scr_h_reg;

    logic                 front_push;
    tcst_pkg::tcst_item_t front_item;
    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;
    tcst_pkg::tcst_item_t q_item;
    logic                 res_valid;
    tcst_pkg::tcst_item_t res_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_en_reg <= 1'b0;
            scr_w_reg  <= 13'd1920;
            scr_h_reg  <= 13'd1080;
        end
        else if (cfg_write)
        begin
            unique case (tcst_pkg::tcst_cfg_idx_t'(cfg_index))
                tcst_pkg::CFG_ENABLE: fwd_en_reg <= cfg_data[0];
                tcst_pkg::CFG_WIDTH:  scr_w_reg  <= cfg_data;
                tcst_pkg::CFG_HEIGHT: scr_h_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    tcst_front #(
        .NUM_IDS   (NUM_IDS),
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .fwd_en         (fwd_en_reg),
        .in_valid       (push && !q_full),
        .first_contact  (first_contact),
        .contact_state  (contact_state),
        .contact_type   (contact_type),
        .contact_id     (contact_id),
        .x_raw          (x_raw),
        .y_raw          (y_raw),
        .contact_width  (contact_width),
        .contact_height (contact_height),
        .q_push         (front_push),
        .q_item         (front_item)
    );

    tcst_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_item  (q_item)
    );

    tcst_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .screen_width  (scr_w_reg),
        .screen_height (scr_h_reg),
        .q_empty       (q_empty),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .res_valid     (res_valid),
        .res_take      (pop),
        .res_item      (res_item)
    );

    assign full        = q_full;
    assign empty       = !res_valid;
    assign out_type    = res_item.typ;
    assign slot_number = res_item.slot;
    assign phase       = res_item.phase;
    assign x_scaled    = res_item.x;
    assign y_scaled    = res_item.y;
    assign out_width   = res_item.w;
    assign out_height  = res_item.h;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import tcst_pkg::*;

    typedef struct {
        logic        first;
        logic [3:0]  st;
        logic [3:0]  typ;
        logic [7:0]  id;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
    } contact_rec_t;

    // Tracks slot ownership per contact id and keeps the emits still owed by the block.
    class slot_tracker_model;
        bit               fwd_en;
        logic [12:0]      scr_w;
        logic [12:0]      scr_h;
        bit               held[NUM_IDS_DEF];
        int unsigned      slot_of[NUM_IDS_DEF];
        tcst_phase_t      ph[NUM_IDS_DEF];
        bit               busy[NUM_SLOTS_DEF];
        bit               skip;
        int unsigned      in_report;
        tcst_item_t       pending_emits[$];
        int unsigned      failures;

        function new();
            fwd_en = 1'b0;
            scr_w = 13'd1920;
            scr_h = 13'd1080;
            for (int i = 0; i < NUM_IDS_DEF; i++)
            begin
                held[i] = 1'b0;
                slot_of[i] = 0;
                ph[i] = PH_DOWN;
            end
            for (int k = 0; k < NUM_SLOTS_DEF; k++)
                busy[k] = 1'b0;
            skip = 1'b0;
            in_report = 0;
            failures = 0;
        endfunction

        function void set_reg(tcst_cfg_idx_t idx, logic [12:0] v);
            case (idx)
                CFG_ENABLE: fwd_en = v[0];
                CFG_WIDTH:  scr_w = v;
                CFG_HEIGHT: scr_h = v;
                default: ;
            endcase
        endfunction

        function logic [15:0] to_screen(logic [15:0] v, logic [12:0] size);
            longint unsigned p;
            p = (longint'(v) * longint'(size)) / FULL_SCALE;
            return (p > 65535) ? 16'hFFFF : p[15:0];
        endfunction

        function void note_contact(contact_rec_t c);
            tcst_item_t  r;
            int unsigned id;
            if (!fwd_en)
                return;
            if (c.first)
            begin
                skip = 1'b0;
                in_report = 0;
            end
            if (skip)
                return;
            if (in_report >= REPORT_CONTACTS)
            begin
                skip = 1'b1;
                return;
            end
            in_report++;
            if ((c.x == 0 && c.y == 0) || c.id >= NUM_IDS_DEF)
            begin
                skip = 1'b1;
                return;
            end
            id = c.id;
            if (c.st == ST_TOUCH)
            begin
                if (!held[id])
                begin
                    // lowest free slot wins
                    for (int k = 0; k < NUM_SLOTS_DEF; k++)
                    begin
                        if (!busy[k])
                        begin
                            busy[k] = 1'b1;
                            held[id] = 1'b1;
                            slot_of[id] = k;
                            ph[id] = PH_DOWN;
                            break;
                        end
                    end
                end
                else if (ph[id] == PH_DOWN)
                    ph[id] = PH_MOVE;
            end
            else if (c.st == ST_LIFT && held[id])
                ph[id] = PH_UP;
            if (!held[id])
                return;
            r.typ = c.typ;
            r.slot = 5'(slot_of[id] + 1);
            r.phase = ph[id];
            r.x = to_screen(c.x, scr_w);
            r.y = to_screen(c.y, scr_h);
            r.w = c.w;
            r.h = c.h;
            pending_emits.push_back(r);
            if (c.st == ST_LIFT)
            begin
                busy[slot_of[id]] = 1'b0;
                held[id] = 1'b0;
                slot_of[id] = 0;
                ph[id] = PH_DOWN;
            end
        endfunction

        function void compare_field(string name, int unsigned e, int unsigned g);
            if (e != g)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, e, g);
                failures++;
            end
        endfunction

        function void check_emit(tcst_item_t got);
            tcst_item_t e;
            if (pending_emits.size() == 0)
            begin
                $error("unexpected result: slot %0d phase %0d", got.slot, got.phase);
                failures++;
                return;
            end
            e = pending_emits.pop_front();
            compare_field("out_type", e.typ, got.typ);
            compare_field("slot_number", e.slot, got.slot);
            compare_field("phase", e.phase, got.phase);
            compare_field("x_scaled", e.x, got.x);
            compare_field("y_scaled", e.y, got.y);
            compare_field("out_width", e.w, got.w);
            compare_field("out_height", e.h, got.h);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        first_contact;
    logic [3:0]  contact_state;
    logic [3:0]  contact_type;
    logic [7:0]  contact_id;
    logic [15:0] x_raw;
    logic [15:0] y_raw;
    logic [15:0] contact_width;
    logic [15:0] contact_height;
    logic        empty;
    logic        pop;
    logic [3:0]  out_type;
    logic [4:0]  slot_number;
    logic [1:0]  phase;
    logic [15:0] x_scaled;
    logic [15:0] y_scaled;
    logic [15:0] out_width;
    logic [15:0] out_height;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    bit                idle_on;
    slot_tracker_model tracker;

    touch_contact_slot_tracker dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .first_contact  (first_contact),
        .contact_state  (contact_state),
        .contact_type   (contact_type),
        .contact_id     (contact_id),
        .x_raw          (x_raw),
        .y_raw          (y_raw),
        .contact_width  (contact_width),
        .contact_height (contact_height),
        .empty          (empty),
        .pop            (pop),
        .out_type       (out_type),
        .slot_number    (slot_number),
        .phase          (phase),
        .x_scaled       (x_scaled),
        .y_scaled       (y_scaled),
        .out_width      (out_width),
        .out_height     (out_height),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // result side: sample at the edge, then choose pop for the next cycle
    initial
    begin
        tcst_item_t got;
        int         stall_left;
        pop = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                got.typ = out_type;
                got.slot = slot_number;
                got.phase = tcst_phase_t'(phase);
                got.x = x_scaled;
                got.y = y_scaled;
                got.w = out_width;
                got.h = out_height;
                tracker.check_emit(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic contact(input logic first, input logic [3:0] st, input logic [3:0] typ,
                           input logic [7:0] id, input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] w, input logic [15:0] h);
        contact_rec_t c;
        int           gap;
        c.first = first;
        c.st = st;
        c.typ = typ;
        c.id = id;
        c.x = x;
        c.y = y;
        c.w = w;
        c.h = h;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 3);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        first_contact <= c.first;
        contact_state <= c.st;
        contact_type <= c.typ;
        contact_id <= c.id;
        x_raw <= c.x;
        y_raw <= c.y;
        contact_width <= c.w;
        contact_height <= c.h;
        @(posedge clk);
        while (full)
            @(posedge clk);
        tracker.note_contact(c);
    endtask

    // wait out owed results, then the pipeline depth for records that emit nothing
    task automatic drain();
        while (tracker.pending_emits.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apply_settings(input bit en, input logic [12:0] w, input logic [12:0] h);
        push <= 1'b0;
        drain();
        cfg_write <= 1'b1;
        cfg_index <= CFG_ENABLE;
        cfg_data <= 13'(en);
        @(posedge clk);
        tracker.set_reg(CFG_ENABLE, 13'(en));
        cfg_index <= CFG_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        tracker.set_reg(CFG_WIDTH, w);
        cfg_index <= CFG_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        tracker.set_reg(CFG_HEIGHT, h);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [15:0] pick_pos();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // one report of well-formed contacts with some noise mixed in
    task automatic random_report(input int lift_pct, output int sent);
        int          n;
        int          r;
        logic        first;
        logic [3:0]  st;
        logic [7:0]  id;
        logic [15:0] x;
        logic [15:0] y;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 8) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
        begin
            first = (i == 0);
            if ($urandom_range(0, 19) == 0)
                first = ~first;
            r = $urandom_range(0, 99);
            if (r < lift_pct)
                st = ST_LIFT;
            else if (r < lift_pct + 60)
                st = ST_TOUCH;
            else
                st = 4'($urandom);
            id = ($urandom_range(0, 99) < 92) ? 8'($urandom_range(0, NUM_IDS_DEF - 1))
                                              : 8'($urandom_range(0, 255));
            x = pick_pos();
            y = pick_pos();
            if ($urandom_range(0, 32) == 0)
            begin
                x = 16'h0000;
                y = 16'h0000;
            end
            contact(first, st, 4'($urandom), id, x, y, 16'($urandom), 16'($urandom));
        end
        sent = n;
    endtask

    task automatic random_phase(input int items, input int lift_pct);
        int done;
        int n;
        done = 0;
        while (done < items)
        begin
            random_report(lift_pct, n);
            done += n;
        end
    endtask

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int junk;
        tracker = new();
        idle_on = 1'b1;
        rst_n = 1'b0;
        push = 1'b0;
        first_contact = 1'b0;
        contact_state = '0;
        contact_type = '0;
        contact_id = '0;
        x_raw = '0;
        y_raw = '0;
        contact_width = '0;
        contact_height = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_ENABLE;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled after reset: these must be dropped
        contact(1'b1, ST_TOUCH, 4'd3, 8'd0, 16'd100, 16'd100, 16'd5, 16'd5);
        contact(1'b0, ST_TOUCH, 4'd3, 8'd1, 16'd200, 16'd200, 16'd5, 16'd5);

        apply_settings(1'b1, 13'd8191, 13'd8191);
        contact(1'b1, ST_TOUCH, 4'd15, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        contact(1'b0, ST_TOUCH, 4'd1, 8'd20, 16'd1, 16'd0, 16'd7, 16'd9);
        contact(1'b0, ST_TOUCH, 4'd2, 8'd0, 16'd32767, 16'd16384, 16'd1, 16'd1);
        contact(1'b0, 4'd3, 4'd4, 8'd20, 16'd500, 16'd600, 16'd2, 16'd3);
        contact(1'b0, ST_LIFT, 4'd5, 8'd0, 16'd32767, 16'd32767, 16'd4, 16'd4);
        contact(1'b0, ST_LIFT, 4'd6, 8'd5, 16'd10, 16'd10, 16'd4, 16'd4);
        // seventh contact in one report
        contact(1'b0, ST_TOUCH, 4'd7, 8'd1, 16'd10, 16'd10, 16'd4, 16'd4);
        contact(1'b1, ST_TOUCH, 4'd8, 8'd1, 16'd0, 16'd0, 16'd4, 16'd4);
        contact(1'b0, ST_TOUCH, 4'd9, 8'd2, 16'd50, 16'd50, 16'd4, 16'd4);
        contact(1'b1, ST_TOUCH, 4'd10, 8'd21, 16'd50, 16'd50, 16'd4, 16'd4);
        contact(1'b1, ST_TOUCH, 4'd0, 8'd255, 16'd0, 16'hFFFF, 16'd0, 16'd0);
        contact(1'b1, ST_TOUCH, 4'd11, 8'd1, 16'd0, 16'd1, 16'd8, 16'd8);
        contact(1'b0, 4'd15, 4'd12, 8'd1, 16'd32767, 16'd32767, 16'd8, 16'd8);
        contact(1'b0, 4'd0, 4'd13, 8'd9, 16'd30, 16'd30, 16'd8, 16'd8);
        contact(1'b0, ST_LIFT, 4'd14, 8'd20, 16'd30, 16'd30, 16'd8, 16'd8);
        contact(1'b0, ST_LIFT, 4'd14, 8'd1, 16'd30, 16'd30, 16'd8, 16'd8);

        apply_settings(1'b1, 13'd1920, 13'd1080);
        random_phase(300, 15);
        apply_settings(1'b1, 13'd8191, 13'd8191);
        random_phase(300, 4);
        apply_settings(1'b1, 13'd0, 13'd0);
        random_phase(300, 25);
        // disabled again: nothing emitted, tracking state must survive
        apply_settings(1'b0, 13'd4000, 13'd3000);
        random_phase(40, 15);
        apply_settings(1'b1, 13'($urandom), 13'($urandom));
        random_phase(300, 10);
        apply_settings(1'b1, 13'd1, 13'd8191);
        random_phase(300, 20);
        idle_on = 1'b0;
        apply_settings(1'b1, 13'd8191, 13'd0);
        random_phase(300, 15);

        push <= 1'b0;
        drain();
        junk = tracker.pending_emits.size();
        if (junk != 0)
        begin
            $error("%0d expected results never arrived", junk);
            tracker.failures++;
        end
        if (tracker.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
src/tcst_pkg.sv
src/tcst_front.sv
src/tcst_queue.sv
src/tcst_back.sv
src/touch_contact_slot_tracker.sv
tb/sv/testbench.sv
